### hdl/vnf_pkg.sv
`default_nettype none
package vnf_pkg;

  localparam int COORD_W = 40;
  localparam int OUT_W   = 16;
  localparam int SEED_W  = 32;
  localparam int OCT_W   = 4;
  localparam int CFG_W   = 32;

  // lattice hash multipliers
  localparam logic [31:0] HASH_MX = 32'd374761393;
  localparam logic [31:0] HASH_MY = 32'd668265263;
  localparam logic [31:0] HASH_MZ = 32'd1274126177;

  localparam logic [31:0] CORNER_MOD = 32'd10000;
  localparam int          SEED_STEP  = 1000;

  // floor(h / 10000) = (h * MOD_RECIP) >> MOD_SHIFT, exact for any 32-bit h
  localparam logic [31:0] MOD_RECIP = 32'd3518437209;
  localparam int          MOD_SHIFT = 45;

  typedef enum logic [0:0] {
    REG_SEED    = 1'b0,
    REG_OCTAVES = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

### hdl/value_noise_fbm_unit.sv
// channel  | handshake                     | payload
// ---------+-------------------------------+--------------------
// cfg      | cfg_write                     | cfg_index, cfg_data
// in       | in_valid / in_stall           | x_coord, y_coord
// out      | out_valid / out_stall         | noise_value
//
// One request per cycle while the output is not stalled; 9 per-octave stages,
// 2 sum stages and an output register. All octaves run in parallel lanes.
// A stall on the output freezes the whole pipe and raises in_stall.
// Reset clears valid bits and loads seed 12345 and 6 octaves.
`default_nettype none
module value_noise_fbm_unit #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [vnf_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [vnf_pkg::COORD_W-1:0]   x_coord,
  input  wire logic [vnf_pkg::COORD_W-1:0]   y_coord,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [vnf_pkg::OUT_W-1:0]     noise_value
);

  localparam int F     = FRAC_BITS;
  localparam int ACC_W = F + MAX_OCTAVES;
  localparam int NG    = (MAX_OCTAVES + 3) / 4;
  localparam int PIPE  = 11;

  logic [vnf_pkg::SEED_W-1:0] noise_seed;
  logic [vnf_pkg::OCT_W-1:0]  octave_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed   <= 32'd12345;
      octave_count <= 4'd6;
    end else if (cfg_write) begin
      case (vnf_pkg::cfg_reg_t'(cfg_index))
        vnf_pkg::REG_SEED:    noise_seed   <= cfg_data[vnf_pkg::SEED_W-1:0];
        vnf_pkg::REG_OCTAVES: octave_count <= cfg_data[vnf_pkg::OCT_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic [PIPE-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[PIPE-2:0], in_valid};
      out_valid <= vld[PIPE-1];
    end
  end

  logic [ACC_W-1:0] term [NG*4];

  for (genvar i = 0; i < NG*4; i++) begin : g_lane
    if (i < MAX_OCTAVES) begin : g_oct
      logic [F-1:0] n;
      vnf_octave #(.FRAC_BITS(F), .OCT(i)) u_oct (
        .clk     (clk),
        .en      (en),
        .x_coord (x_coord),
        .y_coord (y_coord),
        .seed    (noise_seed),
        .n       (n)
      );
      // octaves beyond the count contribute nothing
      assign term[i] = (32'(i) < 32'(octave_count)) ?
                       (ACC_W'(n) << (MAX_OCTAVES - 1 - i)) : '0;
    end else begin : g_pad
      assign term[i] = '0;
    end
  end

  logic [ACC_W-1:0] grp [NG];
  logic [ACC_W-1:0] acc, acc_next;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_ff @(posedge clk) begin
      if (en) begin
        grp[g] <= term[4*g] + term[4*g+1] + term[4*g+2] + term[4*g+3];
      end
    end
  end

  always_comb begin
    acc_next = '0;
    for (int g = 0; g < NG; g++) begin
      acc_next = acc_next + grp[g];
    end
  end

  logic [F-1:0]              total;
  logic [vnf_pkg::OUT_W-1:0] scaled;
  assign total = acc[ACC_W-1:MAX_OCTAVES];

  if (F >= vnf_pkg::OUT_W) begin : g_dn
    assign scaled = total[F-1:F-vnf_pkg::OUT_W];
  end else begin : g_up
    assign scaled = {total, {(vnf_pkg::OUT_W-F){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc         <= acc_next;
      noise_value <= scaled;
    end
  end

`ifndef ASSERT_OFF
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && vld == '0))
    else $error("pipe not empty after reset");

  a_deliver: assert property (@(posedge clk) disable iff (rst)
    (vld[PIPE-1] && en) |=> out_valid)
    else $error("result lost at output register");
`endif

endmodule
`default_nettype wire

### hdl/vnf_octave.sv
`default_nettype none
module vnf_octave #(
  parameter int FRAC_BITS = 16,
  parameter int OCT       = 0
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [vnf_pkg::COORD_W-1:0]   x_coord,
  input  wire logic [vnf_pkg::COORD_W-1:0]   y_coord,
  input  wire logic [vnf_pkg::SEED_W-1:0]    seed,
  output logic      [FRAC_BITS-1:0]          n
);

  localparam int F = FRAC_BITS;
  localparam logic [31:0]  SEED_OFS  = 32'(OCT * vnf_pkg::SEED_STEP);
  localparam logic [F:0]   ONE       = (F+1)'(1) << F;
  localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
  // (r << F) / 10000 by reciprocal, r < 10000
  localparam logic [F+19:0] CV_K = (F+20)'(((64'd1 << (F+32)) / 64'd10000) + 64'd1);

  logic [63:0] xs, ys;
  assign xs = {{(64-vnf_pkg::COORD_W){x_coord[vnf_pkg::COORD_W-1]}}, x_coord} << OCT;
  assign ys = {{(64-vnf_pkg::COORD_W){y_coord[vnf_pkg::COORD_W-1]}}, y_coord} << OCT;

  // stage 1: lattice index and fraction
  logic [31:0]  ix0, iy0;
  logic [F-1:0] fx1, fy1;
  always_ff @(posedge clk) begin
    if (en) begin
      ix0 <= xs[F+31:F] + seed + SEED_OFS;
      iy0 <= ys[F+31:F];
      fx1 <= xs[F-1:0];
      fy1 <= ys[F-1:0];
    end
  end

  // stage 2: hash products, fraction squares
  logic [31:0]    pa, pb;
  logic [2*F-1:0] sqx, sqy;
  logic [F-1:0]   sx, sy, fx2, fy2;
  assign sqx = (2*F)'(fx1) * (2*F)'(fx1);
  assign sqy = (2*F)'(fy1) * (2*F)'(fy1);
  always_ff @(posedge clk) begin
    if (en) begin
      pa  <= ix0 * vnf_pkg::HASH_MX;
      pb  <= iy0 * vnf_pkg::HASH_MY;
      sx  <= sqx[2*F-1:F];
      sy  <= sqy[2*F-1:F];
      fx2 <= fx1;
      fy2 <= fy1;
    end
  end

  // stage 3: corner sums, first xorshift, smoothstep weights
  logic [F+1:0]   gx, gy;
  logic [2*F+1:0] smx, smy;
  logic [F:0]     wx3, wy3, wx4, wy4, wx5, wy5, wx6, wy6, wx7, wy7, wy8;
  logic [31:0]    hc [4];
  assign gx  = THREE_ONE - {1'b0, fx2, 1'b0};
  assign gy  = THREE_ONE - {1'b0, fy2, 1'b0};
  assign smx = (2*F+2)'(sx) * (2*F+2)'(gx);
  assign smy = (2*F+2)'(sy) * (2*F+2)'(gy);
  // corners: 0 (x,y), 1 (x+1,y), 2 (x,y+1), 3 (x+1,y+1)
  assign hc[0] = pa + pb;
  assign hc[1] = pa + vnf_pkg::HASH_MX + pb;
  assign hc[2] = pa + pb + vnf_pkg::HASH_MY;
  assign hc[3] = pa + vnf_pkg::HASH_MX + pb + vnf_pkg::HASH_MY;

  always_ff @(posedge clk) begin
    if (en) begin
      wx3 <= smx[2*F:F];
      wy3 <= smy[2*F:F];
      wx4 <= wx3;
      wy4 <= wy3;
      wx5 <= wx4;
      wy5 <= wy4;
      wx6 <= wx5;
      wy6 <= wy5;
      wx7 <= wx6;
      wy7 <= wy6;
      wy8 <= wy7;
    end
  end

  logic [F-1:0] cv [4];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    logic [31:0] t, m, h2, h2r;
    logic [63:0] qp;
    logic [18:0] q;
    logic [32:0] qm;
    logic [13:0] r;
    logic [F+33:0] cp;

    assign h2 = m ^ (m >> 16);
    assign qp = 64'(h2) * 64'(vnf_pkg::MOD_RECIP);
    assign qm = 33'(q) * 33'(vnf_pkg::CORNER_MOD);
    assign cp = (F+34)'(r) * (F+34)'(CV_K);

    always_ff @(posedge clk) begin
      if (en) begin
        t     <= hc[c] ^ (hc[c] >> 13);
        m     <= t * vnf_pkg::HASH_MZ;
        q     <= qp[vnf_pkg::MOD_SHIFT+18:vnf_pkg::MOD_SHIFT];
        h2r   <= h2;
        r     <= 14'(h2r - qm[31:0]);
        cv[c] <= cp[F+31:32];
      end
    end
  end

  // stage 8/9: bilinear blend
  logic [2*F+1:0] pt, pbt, pn;
  logic [F-1:0]   top, bot;
  assign pt  = (2*F+2)'(cv[0]) * (2*F+2)'(ONE - wx7) + (2*F+2)'(cv[1]) * (2*F+2)'(wx7);
  assign pbt = (2*F+2)'(cv[2]) * (2*F+2)'(ONE - wx7) + (2*F+2)'(cv[3]) * (2*F+2)'(wx7);
  assign pn  = (2*F+2)'(top) * (2*F+2)'(ONE - wy8) + (2*F+2)'(bot) * (2*F+2)'(wy8);

  always_ff @(posedge clk) begin
    if (en) begin
      top <= pt[2*F-1:F];
      bot <= pbt[2*F-1:F];
      n   <= pn[2*F-1:F];
    end
  end

endmodule
`default_nettype wire
